### src/dwrm_pkg.sv
// shared types and mode codes for the rounded multiplier
package dwrm_pkg;
	localparam logic [1:0] MODE_FULL = 2'd0;
	localparam logic [1:0] MODE_HI   = 2'd1;
	localparam logic [1:0] MODE_HH   = 2'd2;
	localparam logic [1:0] MODE_AB32 = 2'd3;
	typedef logic [1:0] mode_t;
endpackage

### src/dwrm_mul_cell.sv
// one word-by-word partial product cell with output register
module dwrm_mul_cell #(
	parameter int WORD_BITS = 32
) (
	input  logic                   clk,
	input  logic [WORD_BITS-1:0]   x,
	input  logic [WORD_BITS-1:0]   y,
	output logic [2*WORD_BITS-1:0] p_q
);
	always_ff @(posedge clk) begin
		p_q <= {{WORD_BITS{1'b0}}, x} * {{WORD_BITS{1'b0}}, y};
	end
endmodule

### src/dwrm_sum_cell.sv
// summation stage cell: per-mode middle sum (rounded except in full mode) and high-part sum
module dwrm_sum_cell #(
	parameter int WORD_BITS = 32
) (
	input  logic                   clk,
	input  dwrm_pkg::mode_t        mode,
	input  logic [2*WORD_BITS-1:0] pll,
	input  logic [2*WORD_BITS-1:0] pab,
	input  logic [2*WORD_BITS-1:0] pba,
	input  logic [2*WORD_BITS-1:0] phh,
	output dwrm_pkg::mode_t        mode_q,
	output logic [2*WORD_BITS-1:0] lo_q,
	output logic [2*WORD_BITS-1:0] hi_q
);
	import dwrm_pkg::*;
	localparam int W = WORD_BITS;
	logic [2*W-1:0] mid;
	logic [2*W-1:0] zl;
	assign zl = {2*W{1'b0}};
	always_comb begin
		mid = zl;
		unique case (mode)
			MODE_FULL: mid = pll;
			MODE_HI: mid = {zl[W-1:0], pll[2*W-1:W]} + {zl[2*W-1:1], pll[W-1]};
			MODE_HH: mid = {zl[W-1:0], pab[W-1:0]} + {zl[W-1:0], pba[W-1:0]}
				+ {zl[W-1:0], pll[2*W-1:W]} + {zl[2*W-1:1], pll[W-1]};
			MODE_AB32: mid = {zl[W-1:0], pll[2*W-1:W]} + {zl[2*W-1:1], pll[W-1]};
			default: mid = zl;
		endcase
	end
	always_ff @(posedge clk) begin
		mode_q <= mode;
		lo_q   <= mid;
		unique case (mode)
			MODE_HH: hi_q <= phh + {zl[W-1:0], pab[2*W-1:W]}
				+ {zl[W-1:0], pba[2*W-1:W]};
			MODE_AB32: hi_q <= pab;
			default: hi_q <= zl;
		endcase
	end
endmodule

### src/double_word_rounded_multiplier_core.sv
// top level of the pipelined rounded double-word multiplier
// usage: drive req_type, operand_a and operand_b with start high; a
// transaction is taken on each edge where start is high and busy is low.
// busy is always low, so one transaction is taken per cycle.
// four partial product cells (low x low, high x low, low x high,
// high x high) run in parallel, then two summing stages follow.
// the result passes the multiplier cell registers, the summing registers and
// the output register; done is high for one cycle with product_out, and
// throughput is one per cycle, as no stage can stall.
// mode 1 gives a zero-extended word in product_out.
// reset clears the valid pipeline; no transaction is in flight after it.
// the receiver cannot stall; results are shown once and not held.
module double_word_rounded_multiplier_core #(
	parameter int WORD_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [63:0] operand_a,
	input  logic [63:0] operand_b,
	output logic        done,
	output logic [63:0] product_out
);
	import dwrm_pkg::*;
	localparam int W = WORD_BITS;
	logic [W-1:0] al, ah, bl, bh, ah_m, bh_m;
	logic [2*W-1:0] pll, pab, pba, phh, lo_s2, hi_s2;
	mode_t mode_s1, mode_s2;
	logic [2:0] vld_q;
	logic [2*W-1:0] r;
	logic [2*W-1:0] zl;

	assign zl = {2*W{1'b0}};
	assign busy = 1'b0;
	assign al = operand_a[W-1:0];
	assign ah = operand_a[2*W-1:W];
	assign bl = operand_b[W-1:0];
	assign bh = operand_b[2*W-1:W];
	assign ah_m = (req_type == MODE_HH || req_type == MODE_AB32) ? ah : '0;
	assign bh_m = (req_type == MODE_HH) ? bh : '0;

	dwrm_mul_cell #(.WORD_BITS(W)) u_ll (.clk(clk), .x(al), .y(bl), .p_q(pll));
	dwrm_mul_cell #(.WORD_BITS(W)) u_ab (.clk(clk), .x(ah_m), .y(bl), .p_q(pab));
	dwrm_mul_cell #(.WORD_BITS(W)) u_ba (.clk(clk), .x(bh_m), .y(al), .p_q(pba));
	dwrm_mul_cell #(.WORD_BITS(W)) u_hh (.clk(clk), .x(ah_m), .y(bh_m), .p_q(phh));

	always_ff @(posedge clk) begin
		mode_s1 <= req_type;
	end

	dwrm_sum_cell #(.WORD_BITS(W)) u_sum (
		.clk(clk), .mode(mode_s1), .pll(pll), .pab(pab), .pba(pba), .phh(phh),
		.mode_q(mode_s2), .lo_q(lo_s2), .hi_q(hi_s2)
	);

	always_comb begin
		unique case (mode_s2)
			MODE_FULL, MODE_HI: r = lo_s2;
			MODE_HH: r = hi_s2 + {zl[W-1:0], lo_s2[2*W-1:W]} + {zl[2*W-1:1], lo_s2[W-1]};
			MODE_AB32: r = hi_s2 + lo_s2;
			default: r = lo_s2;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[1:0], start & ~busy};
		end
	end

	always_ff @(posedge clk) begin
		product_out <= 64'(r);
	end
	assign done = vld_q[2];

	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done) else $error("result lost");
	a_nobusy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy) else $error("busy raised");
	a_hi: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[1] && mode_s2 == MODE_HI) |=> product_out[63:32] == 32'd0 || W != 32)
		else $error("mode 1 not zero extended");
endmodule
